// ===== hw/rtl/qft_pkg.sv =====
// Package for the quoted field tokenizer.
// Holds result kind codes, character constants and the default field size.
// No dependencies.
package qft_pkg;

	localparam int unsigned MAX_FIELD_DEFAULT = 1024;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LENGTH_W = 10;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
	localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
	localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [BYTE_W-1:0] CH_LOWER_N   = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_LOWER_T   = 8'h74;

endpackage

// ===== hw/rtl/quoted_field_tokenizer.sv =====
// Quoted field tokenizer: cuts a byte stream into fields with quote and escape handling.
// Depends on qft_pkg for kind codes and character constants.
//
//  channel | direction | signals                                        | transfer when
//  --------+-----------+------------------------------------------------+-------------------
//  in      | input     | in_valid, in_ready, in_byte                    | in_valid & in_ready
//  out     | output    | out_valid, out_ready, out_kind, out_byte,      | out_valid & out_ready
//          |           | field_length, field_last                       |
//  cfg     | input     | cfg_valid, cfg_ready, cfg_data                 | cfg_valid & cfg_ready
//
// One byte per cycle while the output is not stalled: a byte is held in the input
// register and its result, if any, is registered into the output register.
// The field state is updated in the same cycle as the byte leaves the input register.
// A stalled output holds the input register; the input side keeps taking bytes
// while the output register can empty in the same cycle.
// Reset clears the field state and sets escape_enable to one.
module quoted_field_tokenizer #(
	parameter int unsigned MAX_FIELD = qft_pkg::MAX_FIELD_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [qft_pkg::BYTE_W-1:0]    in_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_kind,
	output logic [qft_pkg::BYTE_W-1:0]    out_byte,
	output logic [qft_pkg::LENGTH_W-1:0]  field_length,
	output logic                          field_last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);
	import qft_pkg::*;

	localparam int unsigned CNT_W = (MAX_FIELD > 2) ? $clog2(MAX_FIELD) : 1;
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FIELD - 1);

	// Input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Field state
	logic             escape_enable_q;
	logic             in_field_q;
	logic             quoted_q;
	logic             esc_pend_q;
	logic [CNT_W-1:0] count_q;

	// Result register
	logic                out_valid_q;
	kind_t               kind_q;
	logic [BYTE_W-1:0]   obyte_q;
	logic [LENGTH_W-1:0] length_q;
	logic                last_q;

	logic process;

	// Next-state and result values
	logic             in_field_n;
	logic             quoted_n;
	logic             esc_pend_n;
	logic [CNT_W-1:0] count_n;
	logic             emit;
	kind_t            kind_n;
	logic [BYTE_W-1:0] obyte_n;
	logic [CNT_W-1:0] length_n;
	logic             last_n;
	logic [CNT_W+LENGTH_W-1:0] length_ext;

	assign process   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || process;
	assign cfg_ready = 1'b1;

	always_comb begin
		logic             quoted_v;
		logic [CNT_W-1:0] count_v;
		logic             do_store;
		logic             do_close;
		logic [BYTE_W-1:0] store_val;
		kind_t            close_kind;
		logic             done;

		quoted_v   = quoted_q;
		count_v    = count_q;
		do_store   = 1'b0;
		do_close   = 1'b0;
		store_val  = byte_s1;
		close_kind = KIND_END;
		done       = 1'b0;

		in_field_n = in_field_q;
		quoted_n   = quoted_q;
		esc_pend_n = esc_pend_q;
		count_n    = count_q;

		if (in_field_q && esc_pend_q) begin
			// The escaped byte is taken literally, but n and t become LF and TAB; NUL is refused.
			esc_pend_n = 1'b0;
			done       = 1'b1;
			if (byte_s1 == CH_NUL) begin
				do_close   = 1'b1;
				close_kind = KIND_ERR;
			end else begin
				do_store = 1'b1;
				if (byte_s1 == CH_LOWER_N) begin
					store_val = CH_LF;
				end else if (byte_s1 == CH_LOWER_T) begin
					store_val = CH_TAB;
				end
			end
		end else if (!in_field_q) begin
			in_field_n = 1'b1;
			count_v    = '0;
			count_n    = '0;
			esc_pend_n = 1'b0;
			if (byte_s1 == CH_QUOTE) begin
				quoted_n = 1'b1;
				done     = 1'b1;
			end else begin
				quoted_v = 1'b0;
				quoted_n = 1'b0;
			end
		end

		if (!done) begin
			if (byte_s1 == CH_NUL) begin
				do_close   = 1'b1;
				close_kind = KIND_ERR;
			end else if (!quoted_v && (byte_s1 == CH_SPACE || byte_s1 == CH_TAB)) begin
				do_close = 1'b1;
			end else if (byte_s1 == CH_BACKSLASH && escape_enable_q) begin
				esc_pend_n = 1'b1;
			end else if (byte_s1 == CH_QUOTE || byte_s1 == CH_LF || byte_s1 == CH_CR) begin
				do_close = 1'b1;
			end else begin
				do_store = 1'b1;
			end
		end

		emit     = 1'b0;
		kind_n   = KIND_DATA;
		obyte_n  = '0;
		length_n = count_v;
		last_n   = 1'b0;

		if (do_close) begin
			emit       = 1'b1;
			kind_n     = close_kind;
			last_n     = 1'b1;
			in_field_n = 1'b0;
			quoted_n   = 1'b0;
			esc_pend_n = 1'b0;
			count_n    = '0;
		end else if (do_store && (count_v < CNT_LIMIT)) begin
			// Bytes past the field limit are dropped without a result.
			emit     = 1'b1;
			obyte_n  = store_val;
			count_n  = count_v + 1'b1;
			length_n = count_v + 1'b1;
		end
	end

	assign length_ext = {{LENGTH_W{1'b0}}, length_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			escape_enable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_field_q <= 1'b0;
			quoted_q   <= 1'b0;
			esc_pend_q <= 1'b0;
			count_q    <= '0;
		end else if (process) begin
			in_field_q <= in_field_n;
			quoted_q   <= quoted_n;
			esc_pend_q <= esc_pend_n;
			count_q    <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && emit) begin
			kind_q   <= kind_n;
			obyte_q  <= obyte_n;
			length_q <= length_ext[LENGTH_W-1:0];
			last_q   <= last_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = kind_q;
	assign out_byte     = obyte_q;
	assign field_length = length_q;
	assign field_last   = last_q;

endmodule

// ===== test/field_token_checker.sv =====
// Checker for the quoted field tokenizer: watches the input, output and register channels.
// Predicts each result from the accepted bytes and compares it field by field.
// Depends on qft_pkg for kind codes, character constants and widths.
module field_token_checker #(
	parameter int unsigned MAX_FIELD = qft_pkg::MAX_FIELD_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [qft_pkg::BYTE_W-1:0]    in_byte,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [1:0]                    out_kind,
	input  logic [qft_pkg::BYTE_W-1:0]    out_byte,
	input  logic [qft_pkg::LENGTH_W-1:0]  field_length,
	input  logic                          field_last,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_data,
	output int unsigned                   mismatches,
	output int unsigned                   pending
);
	import qft_pkg::*;

	typedef struct packed {
		kind_t                kind;
		logic [BYTE_W-1:0]    data;
		logic [LENGTH_W-1:0]  length;
		logic                 last;
	} token_t;

	token_t      want_tokens[$];

	logic        escapes_on;
	logic        field_open;
	logic        field_quoted;
	logic        escape_armed;
	logic [31:0] stored_bytes;

	task automatic close_field(input kind_t kind);
		token_t t;
		t.kind   = kind;
		t.data   = '0;
		t.length = stored_bytes[LENGTH_W-1:0];
		t.last   = 1'b1;
		want_tokens.push_back(t);
		field_open   = 1'b0;
		field_quoted = 1'b0;
		escape_armed = 1'b0;
		stored_bytes = '0;
	endtask

	task automatic store_byte(input logic [BYTE_W-1:0] b);
		token_t t;
		// A full field swallows further bytes without any result.
		if (stored_bytes >= MAX_FIELD - 1)
			return;
		stored_bytes = stored_bytes + 1;
		t.kind   = KIND_DATA;
		t.data   = b;
		t.length = stored_bytes[LENGTH_W-1:0];
		t.last   = 1'b0;
		want_tokens.push_back(t);
	endtask

	task automatic tokenize_byte(input logic [BYTE_W-1:0] b);
		// Escaped byte is stored, even a terminator; n, t give LF, TAB; NUL errs.
		if (field_open && escape_armed) begin
			escape_armed = 1'b0;
			if (b == CH_NUL)
				close_field(KIND_ERR);
			else
				store_byte(b == CH_LOWER_N ? CH_LF : (b == CH_LOWER_T ? CH_TAB : b));
			return;
		end
		if (!field_open) begin
			field_open   = 1'b1;
			stored_bytes = '0;
			escape_armed = 1'b0;
			if (b == CH_QUOTE) begin
				field_quoted = 1'b1;
				return;
			end
			field_quoted = 1'b0;
		end
		if (b == CH_NUL)
			close_field(KIND_ERR);
		else if (!field_quoted && (b == CH_SPACE || b == CH_TAB))
			close_field(KIND_END);
		else if (b == CH_BACKSLASH && escapes_on)
			escape_armed = 1'b1;
		else if (b == CH_QUOTE || b == CH_LF || b == CH_CR)
			close_field(KIND_END);
		else
			store_byte(b);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t t;
		if (!arst_n) begin
			want_tokens.delete();
			escapes_on   = 1'b1;
			field_open   = 1'b0;
			field_quoted = 1'b0;
			escape_armed = 1'b0;
			stored_bytes = '0;
			pending     <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (want_tokens.size() == 0) begin
					$display("%0t: no result expected, actual kind %0d byte %0d length %0d last %0d",
						$time, out_kind, out_byte, field_length, field_last);
					mismatches++;
				end else begin
					t = want_tokens.pop_front();
					check_field("out_kind", t.kind, out_kind);
					check_field("out_byte", t.data, out_byte);
					check_field("field_length", t.length, field_length);
					check_field("field_last", t.last, field_last);
				end
			end
			if (cfg_valid && cfg_ready)
				escapes_on = cfg_data;
			if (in_valid && in_ready)
				tokenize_byte(in_byte);
			pending <= want_tokens.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the quoted field tokenizer: clock, reset, byte stimulus and verdict.
// Depends on qft_pkg, quoted_field_tokenizer and field_token_checker.
module tb_top;
	import qft_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned PHASE_BYTES  = 12;
	localparam int unsigned SETTLE       = 4;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [BYTE_W-1:0]    in_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           out_kind;
	logic [BYTE_W-1:0]    out_byte;
	logic [LENGTH_W-1:0]  field_length;
	logic                 field_last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 cfg_data;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned bytes_sent;
	int unsigned cycle_count;
	bit          tx_calm;
	bit          rx_calm;

	quoted_field_tokenizer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.field_length (field_length),
		.field_last   (field_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	field_token_checker token_watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.field_length (field_length),
		.field_last   (field_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Calm stretches give runs of back-to-back transfers.
	function automatic int unsigned pick_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		if ($urandom_range(0, 31) == 0)
			tx_calm = !tx_calm;
		gap = pick_wait(tx_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// Holds the input until every predicted result has been taken, then lets
	// the pipeline settle with the input still held.
	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_escape(input logic enable);
		wait_results();
		cfg_valid <= 1'b1;
		cfg_data  <= enable;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		do begin
			b = BYTE_W'($urandom_range(1, 255));
		end while (b == CH_QUOTE || b == CH_BACKSLASH || b == CH_LF || b == CH_CR ||
			b == CH_TAB || b == CH_SPACE);
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] escaped_target();
		case ($urandom_range(0, 9))
			0: return CH_LOWER_N;
			1: return CH_LOWER_T;
			2: return CH_QUOTE;
			3: return CH_BACKSLASH;
			4: return CH_SPACE;
			5: return CH_NUL;
			6: return CH_LF;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// One field, mostly well formed; some noise and some broken fields.
	task automatic send_field();
		int unsigned shape;
		int unsigned len;
		int unsigned r;
		logic        quoted;
		shape = $urandom_range(0, 19);
		if (shape < 2) begin
			repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
		end else if (shape == 2) begin
			repeat ($urandom_range(0, 3)) send_byte(plain_byte());
			if ($urandom_range(0, 1)) begin
				send_byte(CH_NUL);
			end else begin
				send_byte(CH_BACKSLASH);
				send_byte(CH_QUOTE);
			end
		end else begin
			quoted = (shape >= 12);
			if (quoted)
				send_byte(CH_QUOTE);
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
			repeat (len) begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					send_byte(CH_BACKSLASH);
					send_byte(escaped_target());
				end else if (quoted && r == 1) begin
					send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
				end else begin
					send_byte(plain_byte());
				end
			end
			if (quoted) begin
				case ($urandom_range(0, 3))
					0: send_byte(CH_LF);
					1: send_byte(CH_CR);
					default: send_byte(CH_QUOTE);
				endcase
			end else begin
				case ($urandom_range(0, 5))
					0: send_byte(CH_TAB);
					1: send_byte(CH_LF);
					2: send_byte(CH_CR);
					3: send_byte(CH_QUOTE);
					default: send_byte(CH_SPACE);
				endcase
			end
		end
	endtask

	initial begin
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			int unsigned stall;
			if ($urandom_range(0, 31) == 0)
				rx_calm = !rx_calm;
			stall = pick_wait(rx_calm);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int unsigned phase;
		int unsigned phase_goal;
		bit          paused;
		in_valid  <= 1'b0;
		in_byte   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		arst_n    <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_escape(1'b1);
		// Quoted field with LF, TAB and quote escapes.
		send_byte(CH_QUOTE); send_byte("a"); send_byte(CH_BACKSLASH); send_byte(CH_LOWER_N);
		send_byte(CH_BACKSLASH); send_byte(CH_LOWER_T); send_byte(CH_BACKSLASH);
		send_byte(CH_QUOTE); send_byte(8'hFF); send_byte(CH_QUOTE);
		// Empty fields closed by their very first byte, then a one-byte field closed by CR.
		send_byte(CH_SPACE); send_byte(CH_LF);
		send_byte(8'h01); send_byte(CH_CR);
		// Escaped NUL inside a quoted field, then a plain NUL.
		send_byte(CH_QUOTE); send_byte(CH_SPACE); send_byte(CH_BACKSLASH); send_byte(CH_NUL);
		send_byte("z"); send_byte(CH_NUL);
		send_byte(CH_QUOTE); send_byte(CH_QUOTE);
		// An escape armed before the register is cleared still completes.
		send_byte(CH_QUOTE); send_byte(CH_BACKSLASH);
		write_escape(1'b0);
		send_byte(CH_LOWER_N); send_byte(CH_BACKSLASH); send_byte(CH_QUOTE);

		// One field long enough to overflow, with an escape among the dropped bytes.
		write_escape(1'b1);
		repeat (MAX_FIELD_DEFAULT + 2) send_byte(plain_byte());
		send_byte(CH_BACKSLASH); send_byte(CH_LOWER_T);
		send_byte(plain_byte()); send_byte(CH_SPACE);

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0, 2: write_escape(1'b0);
				1: write_escape(1'b1);
				default: write_escape(1'($urandom_range(0, 1)));
			endcase
			phase_goal = bytes_sent + PHASE_BYTES;
			paused = 1'b0;
			while (bytes_sent < phase_goal) begin
				send_field();
				if (!paused && bytes_sent >= phase_goal - PHASE_BYTES / 2) begin
					wait_results();
					paused = 1'b1;
				end
			end
		end

		wait_results();
		if (mismatches == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/qft_pkg.sv
hw/rtl/quoted_field_tokenizer.sv
test/field_token_checker.sv
test/tb_top.sv
